/* design/pid_derivative_on_measurement_unit_defines.svh */
// ----------------------------------------------------------------------------
// PID derivative-on-measurement unit: assertion macros
// Shared property forms for the block's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef PID_DERIVATIVE_ON_MEASUREMENT_UNIT_DEFINES_SVH
`define PID_DERIVATIVE_ON_MEASUREMENT_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define PDM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pdm assertion failed");

// next-cycle implication, clocked on clk, off during reset
`define PDM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pdm assertion failed");

`endif

/* design/pdm_pkg.sv */
// ----------------------------------------------------------------------------
// PID derivative-on-measurement package
// Widths, sequencer states, register indexes and saturation helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package pdm_pkg;

  localparam int DataW  = 32;
  localparam int FracW  = 16;
  localparam int ProdW  = 2 * DataW;
  localparam int ProdHiW = ProdW - FracW;
  localparam int SumW   = 50;
  localparam int QuoW   = DataW + 1 + FracW;
  localparam int DenW   = DataW - 1;
  localparam int CfgIdxW = 3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_MUL_E,
    ST_ACC,
    ST_DIV,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_D,
    ST_SUM,
    ST_DONE
  } pdm_state_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAIN_P,
    CFG_GAIN_I,
    CFG_GAIN_D,
    CFG_DRIVE_LOW,
    CFG_DRIVE_HIGH,
    CFG_ACCUM_LOW,
    CFG_ACCUM_HIGH
  } pdm_cfg_idx_t;

  typedef struct packed {
    logic                     start;
    logic signed [DataW:0]    num;
    logic        [DenW-1:0]   den;
  } pdm_div_req_t;

  function automatic logic signed [DataW-1:0] sat_sum(input logic signed [SumW-1:0] v);
    logic [SumW-DataW:0] top;
    logic signed [DataW-1:0] res;
    top = v[SumW-1:DataW-1];
    if (top == '0 || top == '1) begin
      res = v[DataW-1:0];
    end else if (v[SumW-1]) begin
      res = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      res = {1'b0, {(DataW-1){1'b1}}};
    end
    return res;
  endfunction

  function automatic logic signed [DataW-1:0] clamp_pair(input logic signed [DataW-1:0] v,
                                                         input logic signed [DataW-1:0] a,
                                                         input logic signed [DataW-1:0] b);
    logic signed [DataW-1:0] lo;
    logic signed [DataW-1:0] hi;
    logic signed [DataW-1:0] res;
    lo = (a <= b) ? a : b;
    hi = (a <= b) ? b : a;
    if (v < lo) begin
      res = lo;
    end else if (v > hi) begin
      res = hi;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* design/pid_derivative_on_measurement_unit.sv */
// ----------------------------------------------------------------------------
// PID derivative-on-measurement unit
// Q16.16 PID step with clamped integral, derivative on measurement and
// clamped output, sequenced over one shared multiplier and one divider.
// ----------------------------------------------------------------------------
// Sequencing: a clear command or a nonpositive step time goes straight to the
//   done state; the first update after a clear skips the divider, and an
//   update with a derivative waits on the 49 quotient steps of the bit-serial
//   divider and its done strobe.
// Throughput: one item at a time; the next item is taken once the sequencer
//   is back in idle, while the previous result may still wait in the output.
// Reset: gains zero, limits full range, accumulator, last measurement and
//   primed flag cleared, no result pending.
`default_nettype none

`include "pid_derivative_on_measurement_unit_defines.svh"

module pid_derivative_on_measurement_unit
  import pdm_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic [CfgIdxW-1:0]      cfg_index,
  input  wire logic [DataW-1:0]        cfg_data,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic                    in_command,
  input  wire logic signed [DataW-1:0] in_target,
  input  wire logic signed [DataW-1:0] in_measured,
  input  wire logic signed [DataW-1:0] in_step_time,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [DataW-1:0]      out_drive,
  output logic                         out_accepted
);

  logic signed [DataW-1:0] gain_p_r, gain_i_r, gain_d_r;
  logic signed [DataW-1:0] drive_low_r, drive_high_r, accum_low_r, accum_high_r;

  pdm_state_t              state_r, state_nxt;
  logic signed [DataW-1:0] tgt_r, tgt_nxt;
  logic signed [DataW-1:0] meas_r, meas_nxt;
  logic signed [DataW-1:0] dt_r, dt_nxt;
  logic signed [DataW-1:0] err_r, err_nxt;
  logic signed [DataW-1:0] accum_r, accum_nxt;
  logic signed [DataW-1:0] last_r, last_nxt;
  logic                    primed_r, primed_nxt;
  logic signed [DataW-1:0] deriv_r, deriv_nxt;
  logic signed [SumW-1:0]  sum_r, sum_nxt;
  logic signed [DataW-1:0] res_drive_r, res_drive_nxt;
  logic                    res_acc_r, res_acc_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [DataW-1:0] out_drive_r, out_drive_nxt;
  logic                    out_acc_r, out_acc_nxt;

  logic signed [DataW-1:0] mul_a, mul_b;
  logic signed [ProdW-1:0] prod;
  logic signed [SumW-1:0]  prod_hi;
  pdm_div_req_t            div_req;
  logic                    div_done;
  logic signed [DataW-1:0] div_quot;

  logic signed [DataW:0]   diff_tm;
  logic signed [DataW:0]   acc_add;
  logic signed [DataW-1:0] acc_inc;
  logic signed [SumW-1:0]  sum_fin;
  logic                    slot_free;

  pdm_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  pdm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r     <= '0;
      gain_i_r     <= '0;
      gain_d_r     <= '0;
      drive_low_r  <= {1'b1, {(DataW-1){1'b0}}};
      drive_high_r <= {1'b0, {(DataW-1){1'b1}}};
      accum_low_r  <= {1'b1, {(DataW-1){1'b0}}};
      accum_high_r <= {1'b0, {(DataW-1){1'b1}}};
    end else if (cfg_we) begin
      case (pdm_cfg_idx_t'(cfg_index))
        CFG_GAIN_P:     gain_p_r     <= cfg_data;
        CFG_GAIN_I:     gain_i_r     <= cfg_data;
        CFG_GAIN_D:     gain_d_r     <= cfg_data;
        CFG_DRIVE_LOW:  drive_low_r  <= cfg_data;
        CFG_DRIVE_HIGH: drive_high_r <= cfg_data;
        CFG_ACCUM_LOW:  accum_low_r  <= cfg_data;
        CFG_ACCUM_HIGH: accum_high_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      accum_r     <= '0;
      last_r      <= '0;
      primed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      accum_r     <= accum_nxt;
      last_r      <= last_nxt;
      primed_r    <= primed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tgt_r       <= tgt_nxt;
    meas_r      <= meas_nxt;
    dt_r        <= dt_nxt;
    err_r       <= err_nxt;
    deriv_r     <= deriv_nxt;
    sum_r       <= sum_nxt;
    res_drive_r <= res_drive_nxt;
    res_acc_r   <= res_acc_nxt;
    out_drive_r <= out_drive_nxt;
    out_acc_r   <= out_acc_nxt;
  end

  assign prod_hi   = {{(SumW-ProdHiW){prod[ProdW-1]}}, prod[ProdW-1:FracW]};
  assign diff_tm   = {tgt_r[DataW-1], tgt_r} - {meas_r[DataW-1], meas_r};
  assign acc_inc   = sat_sum(prod_hi);
  assign acc_add   = {accum_r[DataW-1], accum_r} + {acc_inc[DataW-1], acc_inc};
  assign sum_fin   = sum_r + prod_hi;
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    tgt_nxt       = tgt_r;
    meas_nxt      = meas_r;
    dt_nxt        = dt_r;
    err_nxt       = err_r;
    accum_nxt     = accum_r;
    last_nxt      = last_r;
    primed_nxt    = primed_r;
    deriv_nxt     = deriv_r;
    sum_nxt       = sum_r;
    res_drive_nxt = res_drive_r;
    res_acc_nxt   = res_acc_r;
    out_valid_nxt = out_valid_r;
    out_drive_nxt = out_drive_r;
    out_acc_nxt   = out_acc_r;
    mul_a         = '0;
    mul_b         = '0;
    div_req.start = 1'b0;
    div_req.num   = {last_r[DataW-1], last_r} - {meas_r[DataW-1], meas_r};
    div_req.den   = dt_r[DenW-1:0];

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          tgt_nxt  = in_target;
          meas_nxt = in_measured;
          dt_nxt   = in_step_time;
          if (in_command) begin
            accum_nxt     = '0;
            last_nxt      = '0;
            primed_nxt    = 1'b0;
            res_drive_nxt = '0;
            res_acc_nxt   = 1'b0;
            state_nxt     = ST_DONE;
          end else if (in_step_time[DataW-1] || in_step_time == '0) begin
            res_drive_nxt = '0;
            res_acc_nxt   = 1'b0;
            state_nxt     = ST_DONE;
          end else begin
            state_nxt = ST_ERR;
          end
        end
      end
      ST_ERR: begin
        err_nxt   = sat_sum({{(SumW-DataW-1){diff_tm[DataW]}}, diff_tm});
        state_nxt = ST_MUL_E;
      end
      ST_MUL_E: begin
        mul_a     = err_r;
        mul_b     = dt_r;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        accum_nxt  = clamp_pair(sat_sum({{(SumW-DataW-1){acc_add[DataW]}}, acc_add}),
                                accum_low_r, accum_high_r);
        last_nxt   = meas_r;
        primed_nxt = 1'b1;
        if (primed_r) begin
          div_req.start = 1'b1;
          state_nxt     = ST_DIV;
        end else begin
          deriv_nxt = '0;
          state_nxt = ST_MUL_P;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          deriv_nxt = div_quot;
          state_nxt = ST_MUL_P;
        end
      end
      ST_MUL_P: begin
        mul_a     = gain_p_r;
        mul_b     = err_r;
        state_nxt = ST_MUL_I;
      end
      ST_MUL_I: begin
        sum_nxt   = prod_hi;
        mul_a     = gain_i_r;
        mul_b     = accum_r;
        state_nxt = ST_MUL_D;
      end
      ST_MUL_D: begin
        sum_nxt   = sum_fin;
        mul_a     = gain_d_r;
        mul_b     = deriv_r;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        res_drive_nxt = clamp_pair(sat_sum(sum_fin), drive_low_r, drive_high_r);
        res_acc_nxt   = 1'b1;
        state_nxt     = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_drive_nxt = res_drive_r;
          out_acc_nxt   = res_acc_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_stall     = (state_r != ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_drive    = out_drive_r;
  assign out_accepted = out_acc_r;

  `PDM_ASSERT_IMP(a_reject_zero, out_valid && !out_accepted, out_drive == '0)
  `PDM_ASSERT_IMP(a_div_done_in_div, div_done, state_r == ST_DIV)
  `PDM_ASSERT_NXT(a_clear_state, in_valid && !in_stall && in_command, !primed_r && accum_r == '0)

endmodule

`default_nettype wire

/* design/pdm_mul.sv */
// ----------------------------------------------------------------------------
// PDM shared multiplier
// Signed 32x32 multiply with a registered 64-bit product.
// ----------------------------------------------------------------------------
`default_nettype none

module pdm_mul
  import pdm_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic signed [DataW-1:0] op_a,
  input  wire logic signed [DataW-1:0] op_b,
  output logic signed [ProdW-1:0]      prod
);

  logic signed [ProdW-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

/* design/pdm_div.sv */
// ----------------------------------------------------------------------------
// PDM restoring divider
// Signed Q16.16 quotient of a measurement change by a positive time step,
// one quotient bit per cycle, truncated toward zero and saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module pdm_div
  import pdm_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire pdm_div_req_t            req,
  output logic                         done,
  output logic signed [DataW-1:0]      quot
);

  localparam int CntW = $clog2(QuoW + 1);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [CntW-1:0]     cnt_r, cnt_nxt;
  logic [DenW-1:0]     rem_r, rem_nxt;
  logic [DenW-1:0]     den_r, den_nxt;
  logic [QuoW-1:0]     quo_r, quo_nxt;
  logic                neg_r, neg_nxt;

  logic [DataW:0]      mag;
  logic [DataW-1:0]    trial;
  logic [DataW-1:0]    diff;
  logic                ge;
  logic signed [SumW-1:0] sval;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
    neg_r <= neg_nxt;
  end

  always_comb begin
    mag   = req.num[DataW] ? (~req.num + 1'b1) : req.num;
    trial = {rem_r, quo_r[QuoW-1]};
    ge    = trial >= {1'b0, den_r};
    diff  = trial - {1'b0, den_r};

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    neg_nxt  = neg_r;

    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      den_nxt  = req.den;
      quo_nxt  = {mag, {FracW{1'b0}}};
      neg_nxt  = req.num[DataW];
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DenW-1:0] : trial[DenW-1:0];
      quo_nxt = {quo_r[QuoW-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CntW'(QuoW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  assign sval = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
  assign quot = sat_sum(sval);
  assign done = done_r;

endmodule

`default_nettype wire

/* tb/pid_derivative_on_measurement_unit_test.sv */
// ----------------------------------------------------------------------------
// PID derivative-on-measurement unit testbench
// Drives Q16.16 update and clear items through the valid/stall channels with
// random gaps and output stalls. Configuration changes only while the unit
// is drained. A behavioral model of the controller predicts each result, and
// every result is compared field by field, in order, with its prediction.
// ----------------------------------------------------------------------------
module pid_derivative_on_measurement_unit_test;
  import pdm_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgSpare = CfgIdxW'(CFG_ACCUM_HIGH + 1);
  localparam logic [DataW-1:0] WordMax = 32'h7FFF_FFFF;
  localparam logic [DataW-1:0] WordMin = 32'h8000_0000;
  localparam logic [DataW-1:0] QOne = 32'h0001_0000;
  localparam int PhaseItems = 130;
  localparam int PhaseCount = 10;

  typedef struct packed {
    logic signed [DataW-1:0] drive;
    logic                    accepted;
  } drive_result_t;

  class pid_drive_scoreboard;
    longint kp, ki, kd;
    longint out_floor, out_ceil, int_floor, int_ceil;
    longint integral, prev_meas;
    bit seeded;
    drive_result_t pending_drives[$];
    int mismatches, checked, updates, rejected, clears;

    function new();
      kp = 0;
      ki = 0;
      kd = 0;
      out_floor = -64'sd2147483648;
      out_ceil = 64'sd2147483647;
      int_floor = -64'sd2147483648;
      int_ceil = 64'sd2147483647;
      integral = 0;
      prev_meas = 0;
      seeded = 0;
    endfunction

    function longint saturate_word(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint bound_between(longint v, longint a, longint b);
      longint lo, hi;
      lo = (a <= b) ? a : b;
      hi = (a <= b) ? b : a;
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function void set_register(logic [CfgIdxW-1:0] idx, logic signed [DataW-1:0] value);
      case (idx)
        CFG_GAIN_P: kp = value;
        CFG_GAIN_I: ki = value;
        CFG_GAIN_D: kd = value;
        CFG_DRIVE_LOW: out_floor = value;
        CFG_DRIVE_HIGH: out_ceil = value;
        CFG_ACCUM_LOW: int_floor = value;
        CFG_ACCUM_HIGH: int_ceil = value;
        default: ;
      endcase
    endfunction

    function void note_update(logic cmd, logic signed [DataW-1:0] tgt,
                              logic signed [DataW-1:0] meas, logic signed [DataW-1:0] dt);
      drive_result_t want;
      longint err, rate, total;
      want.drive = '0;
      want.accepted = 1'b0;
      if (cmd) begin
        integral = 0;
        prev_meas = 0;
        seeded = 0;
        clears++;
      end else if (dt <= 0) begin
        rejected++;
      end else begin
        err = saturate_word(longint'(tgt) - longint'(meas));
        integral = saturate_word(integral + saturate_word((err * longint'(dt)) >>> FracW));
        integral = bound_between(integral, int_floor, int_ceil);
        rate = 0;
        if (seeded)
          rate = saturate_word(((prev_meas - longint'(meas)) * 65536) / longint'(dt));
        prev_meas = meas;
        seeded = 1;
        total = ((kp * err) >>> FracW) + ((ki * integral) >>> FracW) + ((kd * rate) >>> FracW);
        want.drive = DataW'(bound_between(saturate_word(total), out_floor, out_ceil));
        want.accepted = 1'b1;
        updates++;
      end
      pending_drives.push_back(want);
    endfunction

    function void report_mismatch(string what, logic [DataW-1:0] got, logic [DataW-1:0] want);
      mismatches++;
      if (mismatches <= 40)
        $display("MISMATCH result %0d %s: got %h, expected %h", checked, what, got, want);
    endfunction

    function void check_drive(logic signed [DataW-1:0] drive, logic accepted);
      drive_result_t want;
      checked++;
      if (pending_drives.size() == 0) begin
        report_mismatch("arrived with no item pending", drive, '0);
        return;
      end
      want = pending_drives.pop_front();
      if (drive !== want.drive) report_mismatch("drive", drive, want.drive);
      if (accepted !== want.accepted) report_mismatch("accepted", accepted, want.accepted);
    endfunction

    function int pending();
      return pending_drives.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [DataW-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic in_command;
  logic signed [DataW-1:0] in_target;
  logic signed [DataW-1:0] in_measured;
  logic signed [DataW-1:0] in_step_time;
  logic out_valid;
  logic out_stall;
  logic signed [DataW-1:0] out_drive;
  logic out_accepted;

  pid_drive_scoreboard predictor;
  bit calm;
  int settings;
  logic [DataW-1:0] walk_meas;

  pid_derivative_on_measurement_unit DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_target    (in_target),
    .in_measured  (in_measured),
    .in_step_time (in_step_time),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_drive    (out_drive),
    .out_accepted (out_accepted)
  );

  always #5 clk = ~clk;

  function automatic int pick_pause();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [DataW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return WordMax;
      1: return WordMin;
      2, 3: return $urandom();
      default: return $urandom_range(0, 32'h000A_0000) - 32'h0005_0000;
    endcase
  endfunction

  function automatic logic [DataW-1:0] pick_gain();
    case ($urandom_range(0, 7))
      0: return WordMax;
      1: return WordMin;
      2: return $urandom();
      3: return '0;
      default: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
    endcase
  endfunction

  function automatic logic [DataW-1:0] pick_step();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0001;
      1: return WordMax;
      2: return $urandom() & WordMax;
      default: return $urandom_range(32'h0000_0100, 32'h0002_0000);
    endcase
  endfunction

  task automatic pick_limits(output logic [DataW-1:0] lo, output logic [DataW-1:0] hi);
    case ($urandom_range(0, 3))
      0: begin
        lo = WordMin;
        hi = WordMax;
      end
      1: begin
        lo = $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
        hi = $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
      end
      2: begin
        lo = $urandom();
        hi = $urandom();
      end
      default: begin
        hi = $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
        lo = hi + $urandom_range(0, 32'h0010_0000);
      end
    endcase
  endtask

  // receiver: random stall bursts
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      n = pick_pause();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) predictor.check_drive(out_drive, out_accepted);
  end

  task automatic send_update(input logic cmd, input logic [DataW-1:0] tgt,
                             input logic [DataW-1:0] meas, input logic [DataW-1:0] dt);
    int gap;
    gap = pick_pause();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_target <= tgt;
    in_measured <= meas;
    in_step_time <= dt;
    do @(posedge clk); while (in_stall);
    predictor.note_update(cmd, tgt, meas, dt);
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (predictor.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    predictor.set_register(idx, value);
  endtask

  task automatic apply_setting(input logic [DataW-1:0] gp, input logic [DataW-1:0] gi,
                               input logic [DataW-1:0] gd,
                               input logic [DataW-1:0] dlo, input logic [DataW-1:0] dhi,
                               input logic [DataW-1:0] alo, input logic [DataW-1:0] ahi);
    release_input();
    wait_drained();
    write_register(CFG_GAIN_P, gp);
    write_register(CFG_GAIN_I, gi);
    write_register(CFG_GAIN_D, gd);
    write_register(CFG_DRIVE_LOW, dlo);
    write_register(CFG_DRIVE_HIGH, dhi);
    write_register(CFG_ACCUM_LOW, alo);
    write_register(CFG_ACCUM_HIGH, ahi);
    write_register(CfgSpare, $urandom());
    settings++;
  endtask

  task automatic run_phase(input int count);
    int pause_at;
    int kind;
    logic [DataW-1:0] tgt;
    logic [DataW-1:0] dt;
    pause_at = $urandom_range(1, count - 1);
    for (int k = 0; k < count; k++) begin
      if (k == pause_at) begin
        release_input();
        wait_drained();
      end
      if ($urandom_range(0, 7) == 0) walk_meas = pick_value();
      else walk_meas = walk_meas + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      if ($urandom_range(0, 3) == 0) tgt = pick_value();
      else tgt = walk_meas + $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      kind = $urandom_range(0, 99);
      if (kind < 3) begin
        send_update(1'b1, $urandom(), $urandom(), $urandom());
      end else begin
        if (kind < 10) begin
          case ($urandom_range(0, 2))
            0: dt = '0;
            1: dt = WordMin;
            default: dt = -$urandom_range(1, 32'h7FFF_FFFF);
          endcase
        end else begin
          dt = pick_step();
        end
        send_update(1'b0, tgt, walk_meas, dt);
      end
    end
  endtask

  initial begin
    logic [DataW-1:0] dlo, dhi, alo, ahi;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_command = 1'b0;
    in_target = '0;
    in_measured = '0;
    in_step_time = '0;
    calm = 0;
    settings = 1;
    walk_meas = '0;
    predictor = new();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // reset configuration: bad step times, saturated error, clear
    send_update(1'b0, QOne, '0, '0);
    send_update(1'b0, '0, '0, WordMin);
    send_update(1'b0, WordMax, WordMin, WordMax);
    send_update(1'b0, WordMin, WordMax, 32'h0000_0001);
    send_update(1'b1, WordMax, WordMax, WordMax);

    apply_setting(QOne, 32'h0000_8000, 32'h0000_4000, WordMin, WordMax, WordMin, WordMax);
    send_update(1'b0, 32'h0005_0000, 32'h0002_0000, QOne);
    send_update(1'b0, 32'h0005_0000, 32'h0003_0000, 32'h0000_0001);
    send_update(1'b0, '0, WordMin, 32'h0000_0001);
    send_update(1'b0, '0, WordMax, WordMax);
    send_update(1'b0, 32'h1234_0000, QOne, 32'hFFFF_0000);
    send_update(1'b0, 32'hFFFE_0000, 32'h0002_0000, 32'h0000_8000);
    send_update(1'b1, '0, '0, '0);
    send_update(1'b0, 32'h0003_0000, 32'hFFFF_0000, QOne);

    // extreme gains, inverted limit pairs
    apply_setting(WordMax, WordMin, WordMax, 32'h0010_0000, 32'hFFF0_0000,
                  32'h0005_0000, 32'hFFFB_0000);
    send_update(1'b0, WordMax, WordMin, WordMax);
    send_update(1'b0, WordMin, WordMax, 32'h0000_0001);
    send_update(1'b0, '0, '0, QOne);
    send_update(1'b0, QOne, 32'hFFFF_0000, 32'h0000_8000);

    // opposite extremes, collapsed limits
    apply_setting(WordMin, WordMax, WordMin, 32'h0002_0000, 32'h0002_0000, '0, '0);
    send_update(1'b0, 32'h0007_0000, WordMax, 32'h0000_0001);
    send_update(1'b0, 32'hFFF9_0000, WordMin, WordMax);

    for (int p = 0; p < PhaseCount; p++) begin
      pick_limits(dlo, dhi);
      pick_limits(alo, ahi);
      apply_setting(pick_gain(), pick_gain(), pick_gain(), dlo, dhi, alo, ahi);
      calm = (p % 3 == 1);
      run_phase(PhaseItems);
    end

    calm = 0;
    release_input();
    while (predictor.pending() != 0) @(posedge clk);
    repeat (64) @(posedge clk);

    $display("Checked %0d results: %0d updates, %0d rejected step times, %0d clears",
             predictor.checked, predictor.updates, predictor.rejected, predictor.clears);
    $display("Ran under %0d register settings with random gaps and output stalls",
             settings);
    if (predictor.mismatches == 0) begin
      $display("pid_derivative_on_measurement_unit test passed");
    end else begin
      $display("pid_derivative_on_measurement_unit test failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timed out with %0d results outstanding", predictor.pending());
    $display("pid_derivative_on_measurement_unit test failed");
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/pdm_pkg.sv
design/pdm_mul.sv
design/pdm_div.sv
design/pid_derivative_on_measurement_unit.sv
tb/pid_derivative_on_measurement_unit_test.sv
